// ===== rtl/core/vgmp_pkg.sv =====
// Shared types and codes for the VGM command stream player.
`timescale 1ns / 1ps
`default_nettype none

package vgmp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ENABLE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ADDRESS = 1'd1;

    // input word opcodes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_EXHAUST = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // result kinds
    localparam logic [3:0] K_IDLE        = 4'd0;
    localparam logic [3:0] K_CONSUMED    = 4'd1;
    localparam logic [3:0] K_WRITE       = 4'd2;
    localparam logic [3:0] K_WAIT        = 4'd3;
    localparam logic [3:0] K_SAMPLE      = 4'd4;
    localparam logic [3:0] K_REWIND      = 4'd5;
    localparam logic [3:0] K_ENDED       = 4'd6;
    localparam logic [3:0] K_MALFORMED   = 4'd7;
    localparam logic [3:0] K_UNSUPPORTED = 4'd8;
    localparam logic [3:0] K_REFUSED     = 4'd9;

    // stream commands
    localparam logic [3:0] CMD_WAIT_NIB   = 4'h7;
    localparam logic [7:0] CMD_CHIP_WRITE = 8'h5A;
    localparam logic [7:0] CMD_WAIT_N     = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
    localparam logic [7:0] CMD_END        = 8'h66;
    localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
    localparam logic [7:0] CMD_SKIP1_A    = 8'h4F;
    localparam logic [7:0] CMD_SKIP1_B    = 8'h50;
    localparam logic [7:0] CMD_SKIP2_LO   = 8'h51;
    localparam logic [7:0] CMD_SKIP2_HI   = 8'h55;
    localparam logic [7:0] CMD_SKIP2_C    = 8'h58;
    localparam logic [7:0] CMD_SKIP2_D    = 8'h59;
    localparam logic [7:0] CMD_SKIP4      = 8'hE0;
    localparam logic [7:0] BLOCK_MARKER   = 8'h66;

    localparam logic [15:0] WAIT_NTSC_LEN = 16'd735;
    localparam logic [15:0] WAIT_PAL_LEN  = 16'd882;

    typedef enum logic [11:0] {
        PH_CMD  = 12'b0000_0000_0001,
        PH_REG  = 12'b0000_0000_0010,
        PH_VAL  = 12'b0000_0000_0100,
        PH_WLO  = 12'b0000_0000_1000,
        PH_WHI  = 12'b0000_0001_0000,
        PH_MARK = 12'b0000_0010_0000,
        PH_TYPE = 12'b0000_0100_0000,
        PH_SZ0  = 12'b0000_1000_0000,
        PH_SZ1  = 12'b0001_0000_0000,
        PH_SZ2  = 12'b0010_0000_0000,
        PH_SZ3  = 12'b0100_0000_0000,
        PH_SKIP = 12'b1000_0000_0000
    } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/vgm_command_stream_player_core.sv =====
// VGM command stream player: command decoder, wait counter and result register.
// The result word for an accepted input word is registered and appears on m_ in the next cycle.
// Throughput: one word per cycle; s_tready drops only while a result is held by m_tready.
// Every command byte is decoded in a single pass between the state and result registers.
// Reset (aresetn low, synchronous) clears the parser, wait and position counters,
// the loop registers and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module vgm_command_stream_player_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [vgmp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [vgmp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [vgmp_pkg::S_TDATA_W-1:0]      s_tdata,  // stream_byte
    input  wire logic [vgmp_pkg::S_TUSER_W-1:0]      s_tuser,  // op
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // chip_reg, chip_value, rewind_address, bad_command, wait_left, position
    output logic [vgmp_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic [vgmp_pkg::M_TUSER_W-1:0]           m_tuser   // kind
);
    import vgmp_pkg::*;

    logic         loop_en_reg;
    logic [31:0]  loop_addr_reg;

    phase_t       phase_reg, phase_next;
    logic [7:0]   pend_byte_reg, pend_byte_next;
    logic         marker_ok_reg, marker_ok_next;
    logic [31:0]  size_reg, size_next;
    logic [31:0]  skip_reg, skip_next;
    logic [15:0]  wait_reg, wait_next;
    logic [31:0]  sample_reg, sample_next;
    logic         done_reg, done_next;

    logic         m_tvalid_reg;
    logic [3:0]   kind_reg, kind_next;
    logic [M_TDATA_W-1:0] data_reg, data_next;

    logic         s_acc;
    logic [7:0]   b;
    logic [7:0]   chip_reg_o, chip_val_o, bad_o;
    logic [31:0]  rewind_o;
    logic [31:0]  size_full;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign size_full = {b, size_reg[23:0]};

    always_comb begin
        phase_next     = phase_reg;
        pend_byte_next = pend_byte_reg;
        marker_ok_next = marker_ok_reg;
        size_next      = size_reg;
        skip_next      = skip_reg;
        wait_next      = wait_reg;
        sample_next    = sample_reg;
        done_next      = done_reg;
        kind_next      = K_IDLE;
        chip_reg_o     = 8'd0;
        chip_val_o     = 8'd0;
        rewind_o       = 32'd0;
        bad_o          = 8'd0;

        if (s_tuser == OP_RESTART) begin
            phase_next     = PH_CMD;
            pend_byte_next = 8'd0;
            marker_ok_next = 1'b0;
            size_next      = 32'd0;
            skip_next      = 32'd0;
            wait_next      = 16'd0;
            sample_next    = 32'd0;
            done_next      = 1'b0;
        end else if (done_reg) begin
            kind_next = (s_tuser == OP_BYTE) ? K_REFUSED : K_IDLE;
        end else if (s_tuser == OP_EXHAUST) begin
            done_next  = 1'b1;
            wait_next  = 16'd0;
            phase_next = PH_CMD;
            kind_next  = K_ENDED;
        end else if (s_tuser == OP_TICK) begin
            if (wait_reg != 16'd0) begin
                wait_next   = wait_reg - 16'd1;
                sample_next = sample_reg + 32'd1;
                kind_next   = K_SAMPLE;
            end
        end else if (wait_reg != 16'd0) begin
            kind_next = K_REFUSED;
        end else begin
            kind_next = K_CONSUMED;
            case (phase_reg)
                PH_REG: begin
                    pend_byte_next = b;
                    phase_next     = PH_VAL;
                end
                PH_VAL: begin
                    chip_reg_o = pend_byte_reg;
                    chip_val_o = b;
                    phase_next = PH_CMD;
                    kind_next  = K_WRITE;
                end
                PH_WLO: begin
                    pend_byte_next = b;
                    phase_next     = PH_WHI;
                end
                PH_WHI: begin
                    wait_next  = {b, pend_byte_reg};
                    phase_next = PH_CMD;
                    kind_next  = K_WAIT;
                end
                PH_MARK: begin
                    marker_ok_next = (b == BLOCK_MARKER);
                    size_next      = 32'd0;
                    phase_next     = PH_TYPE;
                end
                PH_TYPE: phase_next = PH_SZ0;
                PH_SZ0: begin
                    size_next[7:0] = b;
                    phase_next     = PH_SZ1;
                end
                PH_SZ1: begin
                    size_next[15:8] = b;
                    phase_next      = PH_SZ2;
                end
                PH_SZ2: begin
                    size_next[23:16] = b;
                    phase_next       = PH_SZ3;
                end
                PH_SZ3: begin
                    size_next = size_full;
                    if (!marker_ok_reg) begin
                        phase_next = PH_CMD;
                        kind_next  = K_MALFORMED;
                    end else begin
                        skip_next  = size_full;
                        phase_next = (size_full == 32'd0) ? PH_CMD : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1) begin
                        phase_next = PH_CMD;
                    end
                end
                default: begin
                    phase_next = PH_CMD;
                    if (b[7:4] == CMD_WAIT_NIB) begin
                        wait_next = 16'(b[3:0]) + 16'd1;
                        kind_next = K_WAIT;
                    end else if (b >= CMD_SKIP2_LO && b <= CMD_SKIP2_HI) begin
                        skip_next  = 32'd2;
                        phase_next = PH_SKIP;
                    end else begin
                        case (b)
                            CMD_CHIP_WRITE: phase_next = PH_REG;
                            CMD_WAIT_N:     phase_next = PH_WLO;
                            CMD_WAIT_NTSC: begin
                                wait_next = WAIT_NTSC_LEN;
                                kind_next = K_WAIT;
                            end
                            CMD_WAIT_PAL: begin
                                wait_next = WAIT_PAL_LEN;
                                kind_next = K_WAIT;
                            end
                            CMD_END: begin
                                if (loop_en_reg && loop_addr_reg != 32'd0) begin
                                    sample_next = 32'd0;
                                    rewind_o    = loop_addr_reg;
                                    kind_next   = K_REWIND;
                                end else begin
                                    done_next = 1'b1;
                                    wait_next = 16'd0;
                                    kind_next = K_ENDED;
                                end
                            end
                            CMD_DATA_BLOCK: phase_next = PH_MARK;
                            CMD_SKIP1_A, CMD_SKIP1_B: begin
                                skip_next  = 32'd1;
                                phase_next = PH_SKIP;
                            end
                            CMD_SKIP2_C, CMD_SKIP2_D: begin
                                skip_next  = 32'd2;
                                phase_next = PH_SKIP;
                            end
                            CMD_SKIP4: begin
                                skip_next  = 32'd4;
                                phase_next = PH_SKIP;
                            end
                            default: begin
                                bad_o     = b;
                                kind_next = K_UNSUPPORTED;
                            end
                        endcase
                    end
                end
            endcase
        end

        data_next = {sample_next, wait_next, bad_o, rewind_o, chip_val_o, chip_reg_o};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_en_reg   <= 1'b0;
            loop_addr_reg <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOOP_ENABLE:  loop_en_reg   <= cfg_wdata[0];
                REG_LOOP_ADDRESS: loop_addr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CMD;
            pend_byte_reg <= 8'd0;
            marker_ok_reg <= 1'b0;
            size_reg      <= 32'd0;
            skip_reg      <= 32'd0;
            wait_reg      <= 16'd0;
            sample_reg    <= 32'd0;
            done_reg      <= 1'b0;
        end else if (s_acc) begin
            phase_reg     <= phase_next;
            pend_byte_reg <= pend_byte_next;
            marker_ok_reg <= marker_ok_next;
            size_reg      <= size_next;
            skip_reg      <= skip_next;
            wait_reg      <= wait_next;
            sample_reg    <= sample_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = data_reg;

    // restart always reports idle with a cleared position
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == OP_RESTART |=>
            m_tvalid && m_tuser == K_IDLE && m_tdata[103:72] == 32'd0)
        else $error("restart result wrong");

    // an ended track never keeps a wait pending
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> wait_reg == 16'd0)
        else $error("wait pending after track end");

    // skip phase always has bytes left
    a_skip_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_reg != 32'd0)
        else $error("skip phase with zero count");

    // a sample result advances the position by one
    a_sample_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && kind_next == K_SAMPLE |=> sample_reg == $past(sample_reg) + 32'd1)
        else $error("sample position did not advance");

endmodule

`default_nettype wire
